### hw/rtl/tcl_pkg.sv
// ----------------------------------------------------------------------------
// tcl_pkg
// Shared types, widths and codes of the tile cache with LRU replacement.
// ----------------------------------------------------------------------------
package tcl_pkg;

  localparam int CACHE_ENTRIES = 64;
  localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);

  localparam int X_W = 21;
  localparam int Y_W = 20;
  localparam int Z_W = 5;
  localparam int H_W = 16;

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 80;

  // Operation codes carried on the request tuser bit.
  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_INSERT = 1'b1;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [IDX_W-1:0] rank_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [H_W-1:0]   handle_t;

  localparam rank_t RANK_MAX = rank_t'(CACHE_ENTRIES - 1);
  localparam idx_t  IDX_LAST = idx_t'(CACHE_ENTRIES - 1);
  localparam cnt_t  CNT_FULL = cnt_t'(CACHE_ENTRIES);

  typedef struct packed {
    logic [Z_W-1:0] zoom;
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
  } key_t;

  typedef struct packed {
    key_t    key;
    handle_t handle;
  } entry_t;

  typedef enum logic {
    PH_SCAN,
    PH_UPDATE
  } phase_e;

  // Controller to datapath.
  typedef struct packed {
    logic   start;     // capture the request, clear the trackers
    logic   rewind;    // restart the entry walk at index zero
    logic   step;      // read the entry at the walk index
    phase_e phase;     // what to do with the entry read last cycle
    logic   evict;     // drop the least recent entry
    logic   fill;      // write the new entry into its slot
    logic   load_out;  // move the result into the output register
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic last;      // walk index is on the last entry
    logic hit;       // key was found during the search
    logic insert;    // captured request is an insert
    logic full;      // every entry is valid
    logic out_busy;  // output register holds a result not yet taken
  } sts_t;

endpackage

### hw/rtl/tcl_ctrl.sv
// ----------------------------------------------------------------------------
// tcl_ctrl
// Sequencer of the tile cache: search walk, decision, recency walk, fill.
// ----------------------------------------------------------------------------
module tcl_ctrl import tcl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_TAIL,
    ST_DECIDE,
    ST_UPDATE,
    ST_UPDATE_TAIL,
    ST_FILL,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.phase = PH_SCAN;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start  = 1'b1;
          cmd_o.rewind = 1'b1;
          state_d      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.step = 1'b1;
        if (sts_i.last) begin
          state_d = ST_SCAN_TAIL;
        end
      end
      ST_SCAN_TAIL: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd_o.rewind = 1'b1;
        if (!sts_i.insert) begin
          state_d = sts_i.hit ? ST_UPDATE : ST_FINISH;
        end else if (sts_i.hit) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.evict = sts_i.full;
          state_d     = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd_o.step  = 1'b1;
        cmd_o.phase = PH_UPDATE;
        if (sts_i.last) begin
          state_d = ST_UPDATE_TAIL;
        end
      end
      ST_UPDATE_TAIL: begin
        cmd_o.phase = PH_UPDATE;
        state_d     = sts_i.insert ? ST_FILL : ST_FINISH;
      end
      ST_FILL: begin
        cmd_o.fill = 1'b1;
        state_d    = ST_FINISH;
      end
      ST_FINISH: begin
        if (!sts_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### hw/rtl/tcl_dpath.sv
// ----------------------------------------------------------------------------
// tcl_dpath
// Entry and recency memories, valid bits, search trackers and result register.
// ----------------------------------------------------------------------------
module tcl_dpath import tcl_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cmd_t    cmd_i,
  input  logic    func_i,
  input  key_t    key_i,
  input  handle_t handle_i,
  input  logic    out_ready_i,
  output sts_t    sts_o,
  output logic    out_valid_o,
  output logic    found_o,
  output handle_t entry_handle_o,
  output logic    evicted_o,
  output key_t    evicted_key_o,
  output handle_t evicted_handle_o
);

  // Captured request.
  logic    func_q;
  key_t    key_q;
  handle_t handle_q;

  logic [CACHE_ENTRIES-1:0] valid_q;
  cnt_t                     count_q;

  // Entry walk: read at rd_idx_q, the data is looked at in the next cycle.
  idx_t   rd_idx_q;
  logic   pend_q;
  idx_t   pend_idx_q;

  entry_t ent_mem [CACHE_ENTRIES];
  rank_t  rank_mem [CACHE_ENTRIES];
  entry_t ent_rd_q;
  rank_t  rank_rd_q;

  // Search results.
  logic    hit_q;
  idx_t    hit_idx_q;
  rank_t   hit_rank_q;
  handle_t hit_handle_q;
  logic    vic_q;
  idx_t    vic_idx_q;
  rank_t   vic_rank_q;
  entry_t  vic_entry_q;
  logic    free_q;
  idx_t    free_idx_q;
  logic    evict_q;

  // Result register.
  logic    out_valid_q;
  logic    found_q;
  handle_t entry_handle_q;
  logic    evicted_q;
  key_t    evicted_key_q;
  handle_t evicted_handle_q;

  logic  pend_live;
  idx_t  slot;
  logic  rank_we;
  idx_t  rank_waddr;
  rank_t rank_wdata;
  rank_t rank_aged;

  assign pend_live = pend_q && valid_q[pend_idx_q];
  // A full cache has no free entry, so the new key goes where the victim was.
  assign slot      = evict_q ? vic_idx_q : free_idx_q;

  always_comb begin
    if (func_q == FUNC_LOOKUP) begin
      if (pend_idx_q == hit_idx_q) begin
        rank_aged = '0;
      end else if (rank_rd_q < hit_rank_q) begin
        rank_aged = rank_rd_q + rank_t'(1);
      end else begin
        rank_aged = rank_rd_q;
      end
    end else if (rank_rd_q < RANK_MAX) begin
      rank_aged = rank_rd_q + rank_t'(1);
    end else begin
      rank_aged = rank_rd_q;
    end
  end

  always_comb begin
    rank_we    = 1'b0;
    rank_waddr = pend_idx_q;
    rank_wdata = rank_aged;
    if (cmd_i.fill) begin
      rank_we    = 1'b1;
      rank_waddr = slot;
      rank_wdata = '0;
    end else if (cmd_i.phase == PH_UPDATE && pend_live) begin
      rank_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      ent_rd_q  <= ent_mem[rd_idx_q];
      rank_rd_q <= rank_mem[rd_idx_q];
    end
    if (rank_we) begin
      rank_mem[rank_waddr] <= rank_wdata;
    end
    if (cmd_i.fill) begin
      ent_mem[slot] <= '{key: key_q, handle: handle_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      func_q   <= func_i;
      key_q    <= key_i;
      handle_q <= handle_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q   <= '0;
      pend_q     <= 1'b0;
      pend_idx_q <= '0;
    end else begin
      pend_q     <= cmd_i.step;
      pend_idx_q <= rd_idx_q;
      if (cmd_i.rewind) begin
        rd_idx_q <= '0;
      end else if (cmd_i.step) begin
        rd_idx_q <= rd_idx_q + idx_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
      evict_q <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        evict_q <= 1'b0;
      end else if (cmd_i.evict) begin
        valid_q[vic_idx_q] <= 1'b0;
        count_q            <= count_q - cnt_t'(1);
        evict_q            <= 1'b1;
      end else if (cmd_i.fill) begin
        valid_q[slot] <= 1'b1;
        count_q       <= count_q + cnt_t'(1);
      end
    end
  end

  // Search trackers: first matching entry, least recent entry (lowest index
  // on a tie) and first invalid entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q  <= 1'b0;
      vic_q  <= 1'b0;
      free_q <= 1'b0;
    end else if (cmd_i.start) begin
      hit_q  <= 1'b0;
      vic_q  <= 1'b0;
      free_q <= 1'b0;
    end else if (cmd_i.phase == PH_SCAN && pend_q) begin
      if (pend_live && !hit_q && ent_rd_q.key == key_q) begin
        hit_q <= 1'b1;
      end
      if (pend_live && (!vic_q || rank_rd_q > vic_rank_q)) begin
        vic_q <= 1'b1;
      end
      if (!pend_live && !free_q) begin
        free_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.phase == PH_SCAN && pend_q) begin
      if (pend_live && !hit_q && ent_rd_q.key == key_q) begin
        hit_idx_q    <= pend_idx_q;
        hit_rank_q   <= rank_rd_q;
        hit_handle_q <= ent_rd_q.handle;
      end
      if (pend_live && (!vic_q || rank_rd_q > vic_rank_q)) begin
        vic_idx_q   <= pend_idx_q;
        vic_rank_q  <= rank_rd_q;
        vic_entry_q <= ent_rd_q;
      end
      if (!pend_live && !free_q) begin
        free_idx_q <= pend_idx_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      found_q          <= hit_q;
      entry_handle_q   <= (hit_q && func_q == FUNC_LOOKUP) ? hit_handle_q : '0;
      evicted_q        <= evict_q;
      evicted_key_q    <= evict_q ? vic_entry_q.key : '0;
      evicted_handle_q <= evict_q ? vic_entry_q.handle : '0;
    end
  end

  assign sts_o.last     = (rd_idx_q == IDX_LAST);
  assign sts_o.hit      = hit_q;
  assign sts_o.insert   = (func_q == FUNC_INSERT);
  assign sts_o.full     = (count_q == CNT_FULL);
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign found_o          = found_q;
  assign entry_handle_o   = entry_handle_q;
  assign evicted_o        = evicted_q;
  assign evicted_key_o    = evicted_key_q;
  assign evicted_handle_o = evicted_handle_q;

endmodule

### hw/rtl/tile_cache_lru.sv
// ----------------------------------------------------------------------------
// tile_cache_lru
// Fully associative map tile cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// One request at a time: a lookup or an insert keyed by zoom, column and row.
// The entries sit in memories that are walked one entry per cycle, once
// to search and, when recency changes, once more to age the ranks. A
// lookup miss or an insert of a held key skips the second walk; a lookup
// hit and an insert of a new key take both, and such an insert then fills
// its slot. The next request can be taken in the cycle after the result is
// loaded into the output register, even while that result waits to be
// taken.
// Every request returns exactly one result; on an eviction the evicted key
// and buffer handle are reported so that the owner can free the buffer.
// ----------------------------------------------------------------------------
module tile_cache_lru import tcl_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // tile_x[20:0], tile_y[40:21], zoom[45:41], image_handle[61:46], zero fill
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // func[0]
  input  logic                  s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // found[0], entry_handle[16:1], evicted[17], evicted_x[38:18],
  // evicted_y[58:39], evicted_zoom[63:59], evicted_handle[79:64]
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  cmd_t    cmd;
  sts_t    sts;
  key_t    in_key;
  logic    found;
  handle_t entry_handle;
  logic    evicted;
  key_t    evicted_key;
  handle_t evicted_handle;

  assign in_key.x    = s_axis_tdata_i[20:0];
  assign in_key.y    = s_axis_tdata_i[40:21];
  assign in_key.zoom = s_axis_tdata_i[45:41];

  tcl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tcl_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .func_i           (s_axis_tuser_i),
    .key_i            (in_key),
    .handle_i         (s_axis_tdata_i[61:46]),
    .out_ready_i      (m_axis_tready_i),
    .sts_o            (sts),
    .out_valid_o      (m_axis_tvalid_o),
    .found_o          (found),
    .entry_handle_o   (entry_handle),
    .evicted_o        (evicted),
    .evicted_key_o    (evicted_key),
    .evicted_handle_o (evicted_handle)
  );

  assign m_axis_tdata_o = {evicted_handle, evicted_key.zoom, evicted_key.y,
                           evicted_key.x, evicted, entry_handle, found};

endmodule

### hw/rtl/tcl_checker.sv
// ----------------------------------------------------------------------------
// tcl_checker
// Port-level checks of the tile cache, bound to the top level.
// ----------------------------------------------------------------------------
module tcl_checker import tcl_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_tvalid_i,
  input logic                  s_tready_i,
  input logic                  m_tvalid_i,
  input logic                  m_tready_i,
  input logic [OUT_DATA_W-1:0] m_tdata_i
);

  logic m_found;
  logic m_evicted;

  assign m_found   = m_tdata_i[0];
  assign m_evicted = m_tdata_i[17];

  // A result held back by the consumer stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i))
    else $error("result changed while stalled");

  // Requests are worked one at a time, so an accepted request closes the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_i |=> !s_tready_i)
    else $error("second request taken during a walk");

  // Only an insert of a new key evicts, and such a key was not found.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && m_evicted |-> !m_found && m_tdata_i[16:1] == '0)
    else $error("eviction reported together with a hit");

  // Without an eviction all eviction fields read zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_evicted |-> m_tdata_i[79:18] == '0)
    else $error("eviction fields set without an eviction");

  // A handle is returned only for a key that was found.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && m_tdata_i[16:1] != '0 |-> m_found)
    else $error("handle returned on a miss");

endmodule

bind tile_cache_lru tcl_checker u_tcl_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_axis_tvalid_i),
  .s_tready_i (s_axis_tready_o),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o)
);

### tb/sv/tile_cache_lru_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tile_cache_lru_test
// Self-checking bench for the LRU map tile cache.
// ----------------------------------------------------------------------------
// Requests go in over the slave stream with random gaps. Each accepted request
// runs through a behavioral copy of the cache: entries, handles, ranks and the
// fill count. The bench queues the response that the copy predicts. Responses
// are taken from the master stream under random back-pressure and compared
// field by field with the oldest queued prediction. Traffic is a directed
// set of corner keys, a fill and eviction sequence, and then mixed lookups and
// inserts drawn from working sets smaller than, equal to and larger than the
// table.
// ----------------------------------------------------------------------------
module tile_cache_lru_test;
  import tcl_pkg::*;

  localparam int RESPONSE_LATENCY = 2 * CACHE_ENTRIES + 6;
  localparam int CYCLE_LIMIT      = 1_000_000;
  localparam int MAX_WAIT         = 12;
  localparam int EXPECT_DEPTH     = 8;
  localparam int MAX_SET          = 256;

  typedef struct packed {
    logic           found;
    handle_t        entry_handle;
    logic           evicted;
    logic [X_W-1:0] evicted_x;
    logic [Y_W-1:0] evicted_y;
    logic [Z_W-1:0] evicted_zoom;
    handle_t        evicted_handle;
  } tile_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i = '0;
  logic                  s_axis_tuser_i = FUNC_LOOKUP;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;

  // Behavioral copy of the cache contents.
  bit          cached_valid  [CACHE_ENTRIES];
  key_t        cached_key    [CACHE_ENTRIES];
  handle_t     cached_handle [CACHE_ENTRIES];
  int unsigned cached_rank   [CACHE_ENTRIES];
  int          cached_count;

  // Predictions in order of acceptance, kept in a small ring.
  tile_result_t expected_results [EXPECT_DEPTH];
  int           expect_wr;
  int           expect_rd;
  int           mismatch_count;
  int           stall_left;
  int           cycle_count;
  bit           quiet;

  tile_cache_lru dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic tile_result_t predict_tile_request(input logic func, input key_t key,
                                                        input handle_t handle);
    tile_result_t res;
    int           hit;
    int           victim;
    int           slot;
    int unsigned  hit_rank;
    res    = '0;
    hit    = -1;
    victim = -1;
    slot   = -1;
    for (int i = 0; i < CACHE_ENTRIES; i++)
      if (hit < 0 && cached_valid[i] && cached_key[i] == key) hit = i;

    if (func == FUNC_LOOKUP) begin
      if (hit >= 0) begin
        hit_rank         = cached_rank[hit];
        res.found        = 1'b1;
        res.entry_handle = cached_handle[hit];
        for (int i = 0; i < CACHE_ENTRIES; i++)
          if (cached_valid[i] && cached_rank[i] < hit_rank) cached_rank[i]++;
        cached_rank[hit] = 0;
      end
      return res;
    end

    // Inserting a key that is already held leaves handle and recency alone.
    if (hit >= 0) begin
      res.found = 1'b1;
      return res;
    end

    if (cached_count >= CACHE_ENTRIES) begin
      for (int i = 0; i < CACHE_ENTRIES; i++)
        if (cached_valid[i] && (victim < 0 || cached_rank[i] > cached_rank[victim]))
          victim = i;
      if (victim >= 0) begin
        res.evicted        = 1'b1;
        res.evicted_x      = cached_key[victim].x;
        res.evicted_y      = cached_key[victim].y;
        res.evicted_zoom   = cached_key[victim].zoom;
        res.evicted_handle = cached_handle[victim];
        cached_valid[victim] = 1'b0;
        cached_count--;
      end
    end

    for (int i = 0; i < CACHE_ENTRIES; i++) begin
      if (cached_valid[i]) begin
        if (cached_rank[i] < CACHE_ENTRIES - 1) cached_rank[i]++;
      end else if (slot < 0) begin
        slot = i;
      end
    end

    if (slot >= 0) begin
      cached_valid[slot]  = 1'b1;
      cached_key[slot]    = key;
      cached_handle[slot] = handle;
      cached_rank[slot]   = 0;
      cached_count++;
    end
    return res;
  endfunction

  function automatic key_t random_tile_key();
    key_t k;
    k.x = X_W'($urandom);
    k.y = Y_W'($urandom);
    // Mostly real zoom levels, but the upper codes are legal keys as well.
    if ($urandom_range(0, 7) == 0) k.zoom = Z_W'($urandom_range(21, 31));
    else k.zoom = Z_W'($urandom_range(0, 20));
    return k;
  endfunction

  function automatic key_t make_key(input int zoom, input int x, input int y);
    key_t k;
    k.zoom = Z_W'(zoom);
    k.x    = X_W'(x);
    k.y    = Y_W'(y);
    return k;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(input logic func, input key_t key, input handle_t handle);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tuser_i  = func;
    s_axis_tdata_i  = {2'b00, handle, key.zoom, key.y, key.x};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    expected_results[expect_wr % EXPECT_DEPTH] = predict_tile_request(func, key, handle);
    expect_wr++;
    @(negedge clk_i);
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch in %s: expected %h, got %h", name, want, got);
    end
  endtask

  // Response side: back-pressure counts down only while a response is offered.
  always @(negedge clk_i) begin
    m_axis_tready_i = (stall_left == 0);
    if (stall_left > 0 && m_axis_tvalid_o) stall_left--;
  end

  always @(posedge clk_i) begin : response_check
    tile_result_t want;
    tile_result_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      stall_left = quiet ? 0 : $urandom_range(0, MAX_WAIT);
      got = {m_axis_tdata_o[0], m_axis_tdata_o[16:1], m_axis_tdata_o[17],
             m_axis_tdata_o[38:18], m_axis_tdata_o[58:39], m_axis_tdata_o[63:59],
             m_axis_tdata_o[79:64]};
      if (expect_wr == expect_rd) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("response with nothing outstanding: %h", m_axis_tdata_o);
      end else begin
        want = expected_results[expect_rd % EXPECT_DEPTH];
        expect_rd++;
        compare_field("found", want.found, got.found);
        compare_field("entry_handle", want.entry_handle, got.entry_handle);
        compare_field("evicted", want.evicted, got.evicted);
        compare_field("evicted_x", want.evicted_x, got.evicted_x);
        compare_field("evicted_y", want.evicted_y, got.evicted_y);
        compare_field("evicted_zoom", want.evicted_zoom, got.evicted_zoom);
        compare_field("evicted_handle", want.evicted_handle, got.evicted_handle);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // Corner keys, both operations, held-key inserts and near-miss keys.
  task automatic test_directed_cases();
    key_t ones;
    key_t zero;
    key_t col_max;
    ones    = make_key(31, 2097151, 1048575);
    zero    = make_key(0, 0, 0);
    col_max = make_key(20, 2097151, 0);
    send_request(FUNC_LOOKUP, zero, 16'hffff);
    send_request(FUNC_INSERT, zero, 16'h0000);
    send_request(FUNC_INSERT, ones, 16'hffff);
    send_request(FUNC_INSERT, col_max, 16'h1234);
    send_request(FUNC_INSERT, make_key(0, 0, 1048575), 16'ha5a5);
    send_request(FUNC_LOOKUP, ones, 16'h0000);
    send_request(FUNC_LOOKUP, zero, 16'h5a5a);
    send_request(FUNC_INSERT, ones, 16'h0000);
    send_request(FUNC_LOOKUP, ones, 16'h0000);
    send_request(FUNC_LOOKUP, make_key(30, 2097151, 1048575), 16'h0000);
    send_request(FUNC_INSERT, make_key(21, 2097151, 0), 16'h8001);
    send_request(FUNC_LOOKUP, col_max, 16'h0000);
    send_request(FUNC_LOOKUP, make_key(21, 2097151, 0), 16'h0000);
    send_request(FUNC_LOOKUP, make_key(0, 0, 1048575), 16'h0000);
    send_request(FUNC_LOOKUP, make_key(0, 1, 0), 16'hffff);
  endtask

  // Fill the table, refresh the oldest tile, and make sure later inserts
  // evict around it in age order.
  task automatic test_lru_eviction();
    key_t fresh [CACHE_ENTRIES + 4];
    for (int i = 0; i < CACHE_ENTRIES + 4; i++) fresh[i] = random_tile_key();
    for (int i = 0; i < CACHE_ENTRIES; i++)
      send_request(FUNC_INSERT, fresh[i], handle_t'($urandom));
    send_request(FUNC_LOOKUP, fresh[0], handle_t'($urandom));
    for (int i = CACHE_ENTRIES; i < CACHE_ENTRIES + 4; i++)
      send_request(FUNC_INSERT, fresh[i], handle_t'($urandom));
    send_request(FUNC_LOOKUP, fresh[0], 16'h0000);
    send_request(FUNC_LOOKUP, fresh[1], 16'h0000);
    send_request(FUNC_INSERT, fresh[1], handle_t'($urandom));
    send_request(FUNC_LOOKUP, fresh[1], 16'h0000);
  endtask

  // Random lookups and inserts over a working set; a share of requests use
  // keys outside the set.
  task automatic run_mixed_traffic(input int set_size, input int count,
                                   input int insert_pct);
    key_t    working_set [MAX_SET];
    key_t    k;
    logic    func;
    for (int i = 0; i < set_size; i++) working_set[i] = random_tile_key();
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) == 0) k = random_tile_key();
      else k = working_set[$urandom_range(0, set_size - 1)];
      func = ($urandom_range(0, 99) < insert_pct) ? FUNC_INSERT : FUNC_LOOKUP;
      send_request(func, k, handle_t'($urandom));
    end
  endtask

  task automatic test_small_working_set();
    run_mixed_traffic(8, 150, 50);
  endtask

  task automatic test_resident_set();
    run_mixed_traffic(48, 250, 40);
  endtask

  task automatic test_back_to_back();
    quiet = 1'b1;
    run_mixed_traffic(CACHE_ENTRIES, 200, 40);
    quiet = 1'b0;
  endtask

  task automatic test_thrashing();
    run_mixed_traffic(CACHE_ENTRIES + 8, 300, 45);
  endtask

  task automatic test_sparse_keys();
    run_mixed_traffic(200, 250, 50);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed_cases();
    test_lru_eviction();
    test_small_working_set();
    test_resident_set();
    test_back_to_back();
    test_thrashing();
    test_sparse_keys();

    s_axis_tvalid_i = 1'b0;
    while (expect_wr != expect_rd) @(posedge clk_i);
    repeat (RESPONSE_LATENCY) @(posedge clk_i);

    if (mismatch_count == 0 && expect_wr == expect_rd) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/tcl_pkg.sv
hw/rtl/tcl_ctrl.sv
hw/rtl/tcl_dpath.sv
hw/rtl/tile_cache_lru.sv
hw/rtl/tcl_checker.sv
tb/sv/tile_cache_lru_test.sv
